// ===== rtl/aluf_pkg.sv =====
// ----------------------------------------------------------------------------
// aluf_pkg: types and constants of the accumulator ALU with flags
// Operation codes, flag bit positions and the request and response beats.
// ----------------------------------------------------------------------------
package aluf_pkg;

   // Operation codes; codes 14 and 15 pass the accumulator and flags through
   typedef enum logic [3:0] {
      ACT_ADC  = 4'd0,
      ACT_SBC  = 4'd1,
      ACT_SUB  = 4'd2,
      ACT_AND  = 4'd3,
      ACT_XOR  = 4'd4,
      ACT_OR   = 4'd5,
      ACT_CP   = 4'd6,
      ACT_CPL  = 4'd7,
      ACT_DAA  = 4'd8,
      ACT_RLA  = 4'd9,
      ACT_RLCA = 4'd10,
      ACT_RRA  = 4'd11,
      ACT_INC  = 4'd12,
      ACT_DEC  = 4'd13
   } action_type;

   // Flag bit positions within a flag nibble
   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   // Decimal adjust correction terms and their limits
   localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
   localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
   localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
   localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

   typedef struct packed {
      action_type action;
      logic [7:0] accumulator;
      logic [7:0] operand;
      logic [3:0] flags_in;
   } req_type;

   typedef struct packed {
      logic [7:0] result;
      logic [3:0] flags_out;
   } rsp_type;

endpackage

// ===== rtl/accumulator_alu_with_flags_core.sv =====
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags_core: 8-bit accumulator ALU with Z/N/H/C flags
// Each beat passes the input register, then the result register; 1 beat/cycle.
// busy never rises: one input register and one result register, no stall.
// Synchronous reset clears both valid bits; results go out without back-pressure.
// ----------------------------------------------------------------------------
module accumulator_alu_with_flags_core
   import aluf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   // Input stage: capture each request beat as it is accepted
   req_type  req_ff;
   logic     req_valid_ff;
   logic     accept;

   // Result stage
   rsp_type  rsp_ff;
   rsp_type  rsp_in;
   logic     rsp_valid_ff;

   // Operand views of the registered request
   logic [7:0] acc;
   logic [7:0] opd;
   logic [3:0] fin;
   logic       cin;

   // Adder and subtracter with a spare bit for carry and borrow
   logic [8:0] sum9;
   logic [4:0] half_sum;
   logic       sub_cin;
   logic [8:0] diff9;
   logic [4:0] half_diff;

   // Increment / decrement on the operand byte
   logic [7:0] inc_val;
   logic [7:0] dec_val;

   // Decimal adjust
   logic       daa_hi;
   logic       daa_lo;
   logic [7:0] daa_adj;
   logic [7:0] daa_val;
   logic       daa_c;

   // No internal stall: a new beat is taken every cycle
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign acc = req_ff.accumulator;
   assign opd = req_ff.operand;
   assign fin = req_ff.flags_in;
   assign cin = fin[FLAG_C];

   assign sum9     = {1'b0, acc} + {1'b0, opd} + {8'b0, cin};
   assign half_sum = {1'b0, acc[3:0]} + {1'b0, opd[3:0]} + {4'b0, cin};

   // Only SBC borrows in the incoming carry; SUB and CP start clean
   assign sub_cin   = (req_ff.action == ACT_SBC) ? cin : 1'b0;
   assign diff9     = {1'b0, acc} - {1'b0, opd} - {8'b0, sub_cin};
   assign half_diff = {1'b0, acc[3:0]} - {1'b0, opd[3:0]} - {4'b0, sub_cin};

   assign inc_val = opd + 8'd1;
   assign dec_val = opd - 8'd1;

   // After addition, correct the high digit on carry or a value above 99 BCD
   // and the low digit on half carry or a digit above 9. After subtraction,
   // take back only what the carry and half carry flags call for.
   assign daa_hi  = fin[FLAG_N] ? cin : (cin | (acc > DAA_HI_LIMIT));
   assign daa_lo  = fin[FLAG_N] ? fin[FLAG_H]
                                : (fin[FLAG_H] | (acc[3:0] > DAA_LO_LIMIT));
   assign daa_adj = (daa_hi ? DAA_HI_ADJ : 8'h00) | (daa_lo ? DAA_LO_ADJ : 8'h00);
   assign daa_val = fin[FLAG_N] ? (acc - daa_adj) : (acc + daa_adj);
   assign daa_c   = daa_hi;

   // Operation decode; flags are built as {Z, N, H, C}
   always_comb begin
      rsp_in.result    = acc;
      rsp_in.flags_out = fin;
      case (req_ff.action)
         ACT_ADC: begin
            rsp_in.result    = sum9[7:0];
            rsp_in.flags_out = {(sum9[7:0] == 8'h00), 1'b0, half_sum[4], sum9[8]};
         end
         ACT_SBC, ACT_SUB, ACT_CP: begin
            // Compare keeps the accumulator and reports the flags of SUB
            rsp_in.result    = (req_ff.action == ACT_CP) ? acc : diff9[7:0];
            rsp_in.flags_out = {(diff9[7:0] == 8'h00), 1'b1, half_diff[4], diff9[8]};
         end
         ACT_AND: begin
            rsp_in.result    = acc & opd;
            rsp_in.flags_out = {((acc & opd) == 8'h00), 1'b0, 1'b1, 1'b0};
         end
         ACT_XOR: begin
            rsp_in.result    = acc ^ opd;
            rsp_in.flags_out = {((acc ^ opd) == 8'h00), 3'b000};
         end
         ACT_OR: begin
            rsp_in.result    = acc | opd;
            rsp_in.flags_out = {((acc | opd) == 8'h00), 3'b000};
         end
         ACT_CPL: begin
            rsp_in.result    = ~acc;
            rsp_in.flags_out = {fin[FLAG_Z], 1'b1, 1'b1, cin};
         end
         ACT_DAA: begin
            rsp_in.result    = daa_val;
            rsp_in.flags_out = {(daa_val == 8'h00), fin[FLAG_N], 1'b0, daa_c};
         end
         ACT_RLA: begin
            rsp_in.result    = {acc[6:0], cin};
            rsp_in.flags_out = {3'b000, acc[7]};
         end
         ACT_RLCA: begin
            rsp_in.result    = {acc[6:0], acc[7]};
            rsp_in.flags_out = {3'b000, acc[7]};
         end
         ACT_RRA: begin
            rsp_in.result    = {cin, acc[7:1]};
            rsp_in.flags_out = {3'b000, acc[0]};
         end
         ACT_INC: begin
            // Carry is kept; half carry when the low digit wraps up
            rsp_in.result    = inc_val;
            rsp_in.flags_out = {(inc_val == 8'h00), 1'b0, (opd[3:0] == 4'hF), cin};
         end
         ACT_DEC: begin
            // Carry is kept; half borrow when the low digit wraps down
            rsp_in.result    = dec_val;
            rsp_in.flags_out = {(dec_val == 8'h00), 1'b1, (opd[3:0] == 4'h0), cin};
         end
         default: begin
            // Unused codes: pass accumulator and flags through unchanged
            rsp_in.result    = acc;
            rsp_in.flags_out = fin;
         end
      endcase
   end

   // Payload registers: load the request on accept, the result behind it
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   // Valid bits: advance one stage per cycle, drop on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef NO_ASSERTIONS
   // Every accepted beat shows up as a result behind the input and result registers
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("accepted beat produced no result");

   // No result without a beat accepted ahead of it through both registers
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 2))
      else $error("result strobe without an accepted beat");

   // Compare leaves the accumulator untouched and always sets N
   a_cp_keeps_acc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_item.action == ACT_CP, 2))
      |-> (rsp_item.result == $past(req_item.accumulator, 2)
           && rsp_item.flags_out[FLAG_N]))
      else $error("compare altered the accumulator or cleared N");

   // Rotates clear Z, N and H
   a_rot_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_item.action == ACT_RLA, 2)
                     || $past(req_item.action == ACT_RLCA, 2)
                     || $past(req_item.action == ACT_RRA, 2)))
      |-> (rsp_item.flags_out[3:1] == 3'b000))
      else $error("rotate left Z, N or H set");
`endif

endmodule
